/* hdl/bsr_pkg.sv */
package bsr_pkg;

    // Ring size default
    localparam int BSR_BLOCK_COUNT = 8;

    // Block status codes
    typedef enum logic [1:0] {
        BSR_EMPTY   = 2'd0,
        BSR_WRITING = 2'd1,
        BSR_FULL    = 2'd2,
        BSR_READING = 2'd3
    } bsr_code_t;

    // Request opcodes
    typedef enum logic [1:0] {
        BSR_OP_ACQ_EMPTY = 2'd0,
        BSR_OP_REL_FULL  = 2'd1,
        BSR_OP_ACQ_FULL  = 2'd2,
        BSR_OP_REL_EMPTY = 2'd3
    } bsr_op_t;

    // Input beat
    typedef struct packed {
        bsr_op_t    opcode;
        logic [3:0] range_start;
        logic [3:0] range_end;
    } bsr_in_t;

    // Result beat
    typedef struct packed {
        logic [2:0] grant_start;
        logic [3:0] grant_count;
        logic [3:0] empty_count;
        logic [3:0] full_count;
    } bsr_out_t;

    // Per-item control seen by the update unit
    typedef struct packed {
        bsr_op_t    op;
        logic [3:0] range_start;
        logic [3:0] range_end;
        logic       running;
    } bsr_step_ctrl_t;

    // Update unit result for one block
    typedef struct packed {
        bsr_code_t code;
        logic      grant;
        logic      run;
    } bsr_step_res_t;

endpackage

/* hdl/bsr_ram.sv */
module bsr_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/bsr_step.sv */
module bsr_step
    import bsr_pkg::*;
#(
    parameter int BLOCK_COUNT = BSR_BLOCK_COUNT,
    parameter int PW          = $clog2(BLOCK_COUNT)
) (
    input  bsr_step_ctrl_t  ctrl_i,
    input  logic [PW-1:0]   idx_i,
    input  logic [PW-1:0]   ptr_i,
    input  bsr_code_t       code_i,
    output bsr_step_res_t   res_o
);

    // Compare width covers both the 4-bit range fields and the ring size
    localparam int CMPW = ((PW > 4) ? PW : 4) + 1;

    logic [CMPW-1:0] idx_w;
    logic [CMPW-1:0] rs_w;
    logic [CMPW-1:0] re_w;
    logic            at_ptr;
    logic            in_range;
    logic            run_now;

    assign idx_w    = CMPW'(idx_i);
    assign rs_w     = CMPW'(ctrl_i.range_start);
    assign re_w     = CMPW'(ctrl_i.range_end);
    assign at_ptr   = (idx_i == ptr_i);
    // out-of-bounds start drops the whole range
    assign in_range = (rs_w < CMPW'(BLOCK_COUNT)) && (idx_w >= rs_w) && (idx_w < re_w);
    // empty run begins at the pointer and stops at the first non-empty block
    assign run_now  = (at_ptr || ctrl_i.running) && (code_i == BSR_EMPTY);

    always_comb begin
        res_o.code  = code_i;
        res_o.grant = 1'b0;
        res_o.run   = 1'b0;
        case (ctrl_i.op)
            BSR_OP_ACQ_EMPTY: begin
                res_o.run   = run_now;
                res_o.grant = run_now;
                if (run_now) begin
                    res_o.code = BSR_WRITING;
                end
            end
            BSR_OP_REL_FULL: begin
                if (in_range) begin
                    res_o.code = BSR_FULL;
                end
            end
            BSR_OP_ACQ_FULL: begin
                if (at_ptr && code_i == BSR_FULL) begin
                    res_o.code  = BSR_READING;
                    res_o.grant = 1'b1;
                end
            end
            BSR_OP_REL_EMPTY: begin
                if (in_range) begin
                    res_o.code = BSR_EMPTY;
                end
            end
            default: begin
                res_o.code = code_i;
            end
        endcase
    end

endmodule

/* hdl/audio_block_status_ring.sv */
// Status keeper for a ring of BLOCK_COUNT audio blocks (empty, writing, full,
// reading). Each request beat walks the status memory from block 0 to the
// last block, one block per cycle through a single read-modify-write update
// unit. s_ready and the result beat both return once the request has gone
// through the WALK state for each block, the DRAIN state for the last
// write-back and the DONE state that loads the output register; no new
// request is accepted before then. The result register holds a finished
// beat while the next request walks; the walk waits at its end if that
// beat has not been taken. All blocks read as empty right after reset,
// with no clearing pass.
module audio_block_status_ring
    import bsr_pkg::*;
#(
    parameter int BLOCK_COUNT = BSR_BLOCK_COUNT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  bsr_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output bsr_out_t m_data
);

    localparam int PW = $clog2(BLOCK_COUNT);
    localparam int CW = $clog2(BLOCK_COUNT + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    bsr_in_t          item_reg, item_next;
    logic [PW-1:0]    idx_reg, idx_next;
    logic             pipe_vld_reg, pipe_vld_next;
    logic [PW-1:0]    pipe_idx_reg, pipe_idx_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             running_reg, running_next;
    logic [CW-1:0]    gcnt_reg, gcnt_next;
    logic [CW-1:0]    ecnt_reg, ecnt_next;
    logic [CW-1:0]    fcnt_reg, fcnt_next;
    logic [PW-1:0]    prod_ptr_reg, prod_ptr_next;
    logic [PW-1:0]    cons_ptr_reg, cons_ptr_next;
    logic [BLOCK_COUNT-1:0] vld_reg, vld_next;
    logic             m_valid_reg, m_valid_next;
    bsr_out_t         m_data_reg, m_data_next;

    logic [1:0]       rd_data;
    bsr_code_t        code_old;
    bsr_step_ctrl_t   step_ctrl;
    bsr_step_res_t    step_res;
    logic [PW-1:0]    step_ptr;
    logic             out_free;
    logic             use_cons;
    logic [CW:0]      ptr_sum;
    logic [PW-1:0]    ptr_new;

    // Status memory: one read, one write-back per cycle
    bsr_ram #(
        .WIDTH (2),
        .DEPTH (BLOCK_COUNT),
        .AW    (PW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (pipe_vld_reg),
        .wr_addr (pipe_idx_reg),
        .wr_data (step_res.code),
        .rd_en   (state_reg == ST_WALK),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // Never-written blocks read as empty
    assign code_old = rd_vld_reg ? bsr_code_t'(rd_data) : BSR_EMPTY;

    // Shared per-block update unit
    assign step_ctrl.op          = item_reg.opcode;
    assign step_ctrl.range_start = item_reg.range_start;
    assign step_ctrl.range_end   = item_reg.range_end;
    assign step_ctrl.running     = running_reg;
    assign use_cons = (item_reg.opcode == BSR_OP_ACQ_FULL) ||
                      (item_reg.opcode == BSR_OP_REL_EMPTY);
    assign step_ptr = use_cons ? cons_ptr_reg : prod_ptr_reg;

    bsr_step #(
        .BLOCK_COUNT (BLOCK_COUNT),
        .PW          (PW)
    ) u_step (
        .ctrl_i (step_ctrl),
        .idx_i  (pipe_idx_reg),
        .ptr_i  (step_ptr),
        .code_i (code_old),
        .res_o  (step_res)
    );

    // Pointer advance after a grant, wrapping at the ring end
    assign ptr_sum = (CW+1)'(step_ptr) + (CW+1)'(gcnt_reg);
    assign ptr_new = (ptr_sum >= (CW+1)'(BLOCK_COUNT)) ? '0 : PW'(ptr_sum);

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        idx_next      = idx_reg;
        pipe_vld_next = 1'b0;
        pipe_idx_next = idx_reg;
        rd_vld_next   = vld_reg[idx_reg];
        running_next  = running_reg;
        gcnt_next     = gcnt_reg;
        ecnt_next     = ecnt_reg;
        fcnt_next     = fcnt_reg;
        prod_ptr_next = prod_ptr_reg;
        cons_ptr_next = cons_ptr_reg;
        vld_next      = vld_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        // write-back and tally of the block in flight
        if (pipe_vld_reg) begin
            vld_next[pipe_idx_reg] = 1'b1;
            running_next = step_res.run;
            gcnt_next    = gcnt_reg + CW'(step_res.grant);
            ecnt_next    = ecnt_reg + CW'(step_res.code == BSR_EMPTY);
            fcnt_next    = fcnt_reg + CW'(step_res.code == BSR_FULL);
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next    = s_data;
                    idx_next     = '0;
                    running_next = 1'b0;
                    gcnt_next    = '0;
                    ecnt_next    = '0;
                    fcnt_next    = '0;
                    state_next   = ST_WALK;
                end
            end
            ST_WALK: begin
                pipe_vld_next = 1'b1;
                if (idx_reg == PW'(BLOCK_COUNT - 1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.grant_start = 3'(step_ptr);
                    m_data_next.grant_count = 4'(gcnt_reg);
                    m_data_next.empty_count = 4'(ecnt_reg);
                    m_data_next.full_count  = 4'(fcnt_reg);
                    if (item_reg.opcode == BSR_OP_ACQ_EMPTY) begin
                        prod_ptr_next = ptr_new;
                    end
                    if (item_reg.opcode == BSR_OP_ACQ_FULL) begin
                        cons_ptr_next = ptr_new;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pipe_vld_reg <= 1'b0;
            prod_ptr_reg <= '0;
            cons_ptr_reg <= '0;
            vld_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pipe_vld_reg <= pipe_vld_next;
            prod_ptr_reg <= prod_ptr_next;
            cons_ptr_reg <= cons_ptr_next;
            vld_reg      <= vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        idx_reg      <= idx_next;
        pipe_idx_reg <= pipe_idx_next;
        rd_vld_reg   <= rd_vld_next;
        running_reg  <= running_next;
        gcnt_reg     <= gcnt_next;
        ecnt_reg     <= ecnt_next;
        fcnt_reg     <= fcnt_next;
        m_data_reg   <= m_data_next;
    end

    // Write-back only happens during the walk and its drain cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_vld_reg |-> (state_reg == ST_WALK || state_reg == ST_DRAIN))
        else $error("status write-back outside the walk");

    // Accepted request starts a walk
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_WALK))
        else $error("accepted request did not start a walk");

    // Empty and full tallies never exceed the ring
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |->
            ((CW+1)'(ecnt_reg) + (CW+1)'(fcnt_reg) <= (CW+1)'(BLOCK_COUNT)))
        else $error("status tallies exceed ring size");

    // Acquire-full grants at most one block
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && item_reg.opcode == BSR_OP_ACQ_FULL) |->
            (gcnt_reg <= CW'(1)))
        else $error("acquire-full granted more than one block");

    // Pointers stay inside the ring
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((CW+1)'(prod_ptr_reg) < (CW+1)'(BLOCK_COUNT)) &&
        ((CW+1)'(cons_ptr_reg) < (CW+1)'(BLOCK_COUNT)))
        else $error("ring pointer out of range");

endmodule
